### sv/dspc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspc_pkg
// shared constants of the straight-drive profile controller
// ----------------------------------------------------------------------------
package dspc_pkg;

  // width of the shared compare-subtract unit and of the remainder registers
  localparam int ARITH_W = 28;

  // request modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  localparam int TARGET_W  = 20;
  localparam int TIMEOUT_W = 16;
  localparam int CFG_W     = 20;

  localparam logic [TARGET_W-1:0]  TARGET_RST  = 20'd500;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd300;

  // profile full scale: 100^4
  localparam logic [ARITH_W-1:0] PROFILE_FULL = 28'd100000000;

  // reciprocals for constant division (value * recip >> shift)
  localparam logic [13:0] RECIP_100 = 14'd5243;  // shift 19, valid to 10000
  localparam logic [13:0] RECIP_10  = 14'd205;   // shift 11, valid to 1009

  // left speed saturates once the scaled sum reaches 10 * 101
  localparam int LEFT_SAT_T = 1010;
  localparam logic signed [7:0] SPEED_LIMIT = 8'sd100;

  // iteration counts
  localparam logic [2:0] DIV_TOP  = 3'd6;   // quotient bits 6..0
  localparam logic [3:0] SQRT_TOP = 4'd13;  // root bit pairs 13..0

endpackage

### sv/dspc_csub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspc_csub
// shared compare-subtract step for the long divider and the square root
// ----------------------------------------------------------------------------
module dspc_csub
  import dspc_pkg::*;
(
  input  logic [ARITH_W-1:0] rem,
  input  logic [ARITH_W-1:0] trial,
  output logic               ge,
  output logic [ARITH_W-1:0] diff
);

  logic [ARITH_W:0] sub;

  assign sub  = {1'b0, rem} - {1'b0, trial};
  assign ge   = ~sub[ARITH_W];
  assign diff = sub[ARITH_W-1:0];

endmodule

### sv/drive_straight_profile_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_straight_profile_controller_core
// straight-drive speed profile and heading correction for a two-wheel base
// ----------------------------------------------------------------------------
// One request is handled at a time. Tick, start and unused-mode requests, and
// samples that end the move, answer at once: the result is registered at the
// accepting edge. A sample that continues the move runs through a small
// sequencer around one compare-subtract unit and one 14x14 multiplier: scale
// check, the 7-bit long division pos*100/target, s^2 and s^4, the integer
// square root of 1e8 - s^4, divide by 100, correction sum, saturation, divide
// by 10 (skipped when saturated) and result load; a sample past the target
// skips the division, the squares and the root. The long division and the
// root share the compare-subtract unit. A new request is taken once the
// sequencer is idle and the result register is free or being taken.
// ----------------------------------------------------------------------------
module drive_straight_profile_controller_core
  import dspc_pkg::*;
#(
  parameter int COUNT_BITS = 21,
  parameter int TICK_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_mode,
  input  logic signed [COUNT_BITS-1:0] in_left_count,
  input  logic signed [COUNT_BITS-1:0] in_right_count,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [7:0]            out_left_cmd,
  output logic [6:0]                   out_right_speed,
  output logic                         out_drive_valid,
  output logic                         out_moving,
  output logic                         out_timeout_hit,
  // configuration writes
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata
);

  // comparison widths so that any count or tick width lines up with the registers
  localparam int CMP_W  = (COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W;
  localparam int TCMP_W = (TICK_BITS > TIMEOUT_W) ? TICK_BITS : TIMEOUT_W;
  // correction sum: 10*base + 9*(right - left)
  localparam int TW     = COUNT_BITS + 6;

  localparam logic signed [TW-1:0] T_HI = TW'(LEFT_SAT_T);
  localparam logic signed [TW-1:0] T_LO = -T_HI;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_DIV,
    S_SQ1,
    S_SQ2,
    S_SQRT,
    S_DIV100,
    S_MIX,
    S_SAT,
    S_DIV10,
    S_DONE
  } state_t;

  state_t                         st_r, st_nxt;
  logic [TARGET_W-1:0]            tgt_r, tgt_nxt;
  logic [TIMEOUT_W-1:0]           tmo_r, tmo_nxt;
  logic                           running_r, running_nxt;
  logic [COUNT_BITS-1:0]          last_pos_r, last_pos_nxt;
  logic [TICK_BITS-1:0]           tick_r, tick_nxt;
  logic                           tflag_r, tflag_nxt;

  // working registers of the sample sequence
  logic [COUNT_BITS-1:0]          pos_r, pos_nxt;
  logic signed [COUNT_BITS:0]     diff_r, diff_nxt;
  logic [ARITH_W-1:0]             rem_r, rem_nxt;
  logic [6:0]                     q_r, q_nxt;
  logic [2:0]                     cnt_r, cnt_nxt;
  logic [13:0]                    sq_r, sq_nxt;
  logic [ARITH_W-1:0]             root_r, root_nxt;
  logic [3:0]                     k_r, k_nxt;
  logic [6:0]                     base_r, base_nxt;
  logic signed [TW-1:0]           t_r, t_nxt;
  logic [9:0]                     mag_r, mag_nxt;
  logic                           neg_r, neg_nxt;
  logic signed [7:0]              lsp_r, lsp_nxt;

  // result register
  logic                           out_valid_r, out_valid_nxt;
  logic signed [7:0]              out_left_r, out_left_nxt;
  logic [6:0]                     out_right_r, out_right_nxt;
  logic                           out_dv_r, out_dv_nxt;
  logic                           out_mov_r, out_mov_nxt;
  logic                           out_tmo_r, out_tmo_nxt;

  // request decode
  logic                           out_free;
  logic                           accept;
  logic signed [COUNT_BITS:0]     sum_in;
  logic [COUNT_BITS:0]            sum_mag;
  logic [COUNT_BITS-1:0]          pos_in;
  logic signed [COUNT_BITS:0]     diff_in;
  logic                           last_lt;
  logic [TICK_BITS-1:0]           tick_inc;

  // datapath helpers
  logic [CMP_W-1:0]               pos_ext;
  logic [CMP_W-1:0]               dist_ext;
  logic [ARITH_W-1:0]             num28;
  logic [ARITH_W-1:0]             div_trial;
  logic [ARITH_W-1:0]             sqrt_bit;
  logic [ARITH_W-1:0]             sqrt_trial;
  logic [ARITH_W-1:0]             cs_trial;
  logic                           cs_ge;
  logic [ARITH_W-1:0]             cs_diff;
  logic [13:0]                    mul_a;
  logic [13:0]                    mul_b;
  logic [ARITH_W-1:0]             mul_p;
  logic signed [TW-1:0]           d_ext;
  logic signed [TW-1:0]           b_ext;
  logic signed [TW-1:0]           t_abs;

  // ---------------------------------------------------------------- handshake
  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = (st_r == S_IDLE) & out_free;
  assign accept   = in_valid & in_ready;

  // position is |trunc((left + right) / 2)|, which is |left + right| >> 1
  assign sum_in  = (COUNT_BITS+1)'(in_left_count) + (COUNT_BITS+1)'(in_right_count);
  assign sum_mag = sum_in[COUNT_BITS] ? -sum_in : sum_in;
  assign pos_in  = sum_mag[COUNT_BITS:1];
  assign diff_in = (COUNT_BITS+1)'(in_right_count) - (COUNT_BITS+1)'(in_left_count);

  assign last_lt  = CMP_W'(last_pos_r) < CMP_W'(tgt_r);
  // tick count saturates at all ones
  assign tick_inc = (tick_r != '1) ? tick_r + TICK_BITS'(1) : tick_r;

  // ---------------------------------------------------------------- datapath
  assign pos_ext  = CMP_W'(pos_r);
  assign dist_ext = CMP_W'(tgt_r);
  // pos < target here, so pos fits the target width and pos*100 fits 27 bits
  assign num28    = ARITH_W'(pos_ext[TARGET_W-1:0]);

  assign div_trial  = ARITH_W'(tgt_r) << cnt_r;
  assign sqrt_bit   = ARITH_W'(1) << {k_r, 1'b0};
  assign sqrt_trial = root_r + sqrt_bit;
  assign cs_trial   = (st_r == S_DIV) ? div_trial : sqrt_trial;

  dspc_csub u_csub (
    .rem   (rem_r),
    .trial (cs_trial),
    .ge    (cs_ge),
    .diff  (cs_diff)
  );

  // shared multiplier operand select
  always_comb begin
    case (st_r)
      S_SQ1: begin
        mul_a = {7'd0, q_r};
        mul_b = {7'd0, q_r};
      end
      S_SQ2: begin
        mul_a = sq_r;
        mul_b = sq_r;
      end
      S_DIV100: begin
        mul_a = root_r[13:0];
        mul_b = RECIP_100;
      end
      S_DIV10: begin
        mul_a = {4'd0, mag_r};
        mul_b = RECIP_10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign d_ext = TW'(diff_r);
  assign b_ext = $signed(TW'(base_r));
  assign t_abs = t_r[TW-1] ? -t_r : t_r;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    st_nxt        = st_r;
    tgt_nxt       = tgt_r;
    tmo_nxt       = tmo_r;
    running_nxt   = running_r;
    last_pos_nxt  = last_pos_r;
    tick_nxt      = tick_r;
    tflag_nxt     = tflag_r;
    pos_nxt       = pos_r;
    diff_nxt      = diff_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    sq_nxt        = sq_r;
    root_nxt      = root_r;
    k_nxt         = k_r;
    base_nxt      = base_r;
    t_nxt         = t_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    lsp_nxt       = lsp_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_dv_nxt    = out_dv_r;
    out_mov_nxt   = out_mov_r;
    out_tmo_nxt   = out_tmo_r;

    // configuration writes; the user must issue them only while idle, the block does not enforce it
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET:  tgt_nxt = cfg_wdata[TARGET_W-1:0];
        REG_TIMEOUT: tmo_nxt = cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_TICK: begin
              if (running_r && (tmo_r != '0) && !tflag_r) begin
                tick_nxt = tick_inc;
                if (TCMP_W'(tick_inc) >= TCMP_W'(tmo_r)) begin
                  tflag_nxt = 1'b1;
                end
              end
            end
            MODE_SAMPLE: begin
              if (running_r && last_lt && !tflag_r) begin
                pos_nxt      = pos_in;
                diff_nxt     = diff_in;
                last_pos_nxt = pos_in;
                st_nxt       = S_SCALE;
              end else begin
                running_nxt = 1'b0;
              end
            end
            MODE_START: begin
              running_nxt  = 1'b1;
              last_pos_nxt = pos_in;
              tick_nxt     = '0;
              tflag_nxt    = 1'b0;
            end
            default: ;
          endcase
          // everything but a continuing sample answers with status only
          if (st_nxt == S_IDLE) begin
            out_valid_nxt = 1'b1;
            out_left_nxt  = '0;
            out_right_nxt = '0;
            out_dv_nxt    = 1'b0;
            out_mov_nxt   = running_nxt;
            out_tmo_nxt   = tflag_nxt;
          end
        end
      end

      S_SCALE: begin
        if (pos_ext >= dist_ext) begin
          // past the target: zero root gives zero base
          root_nxt = '0;
          st_nxt   = S_DIV100;
        end else begin
          rem_nxt = (num28 << 6) + (num28 << 5) + (num28 << 2);
          q_nxt   = '0;
          cnt_nxt = DIV_TOP;
          st_nxt  = S_DIV;
        end
      end

      // restoring division, one quotient bit a cycle
      S_DIV: begin
        q_nxt = {q_r[5:0], cs_ge};
        if (cs_ge) begin
          rem_nxt = cs_diff;
        end
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == '0) begin
          st_nxt = S_SQ1;
        end
      end

      S_SQ1: begin
        sq_nxt = mul_p[13:0];
        st_nxt = S_SQ2;
      end

      S_SQ2: begin
        rem_nxt  = PROFILE_FULL - mul_p;
        root_nxt = '0;
        k_nxt    = SQRT_TOP;
        st_nxt   = S_SQRT;
      end

      // digit-by-digit square root, one bit pair a cycle
      S_SQRT: begin
        if (cs_ge) begin
          rem_nxt  = cs_diff;
          root_nxt = (root_r >> 1) + sqrt_bit;
        end else begin
          root_nxt = root_r >> 1;
        end
        k_nxt = k_r - 4'd1;
        if (k_r == '0) begin
          st_nxt = S_DIV100;
        end
      end

      S_DIV100: begin
        base_nxt = mul_p[25:19];
        st_nxt   = S_MIX;
      end

      S_MIX: begin
        t_nxt  = (d_ext <<< 3) + d_ext + (b_ext <<< 3) + (b_ext <<< 1);
        st_nxt = S_SAT;
      end

      S_SAT: begin
        if (t_r >= T_HI) begin
          lsp_nxt = SPEED_LIMIT;
          st_nxt  = S_DONE;
        end else if (t_r <= T_LO) begin
          lsp_nxt = -SPEED_LIMIT;
          st_nxt  = S_DONE;
        end else begin
          neg_nxt = t_r[TW-1];
          mag_nxt = t_abs[9:0];
          st_nxt  = S_DIV10;
        end
      end

      // truncation toward zero: divide the magnitude, then restore the sign
      S_DIV10: begin
        lsp_nxt = neg_r ? -$signed({1'b0, mul_p[17:11]}) : $signed({1'b0, mul_p[17:11]});
        st_nxt  = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = lsp_r;
          out_right_nxt = base_r;
          out_dv_nxt    = 1'b1;
          out_mov_nxt   = running_r;
          out_tmo_nxt   = tflag_r;
          st_nxt        = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      tgt_r       <= TARGET_RST;
      tmo_r       <= TIMEOUT_RST;
      running_r   <= 1'b0;
      last_pos_r  <= '0;
      tick_r      <= '0;
      tflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tgt_r       <= tgt_nxt;
      tmo_r       <= tmo_nxt;
      running_r   <= running_nxt;
      last_pos_r  <= last_pos_nxt;
      tick_r      <= tick_nxt;
      tflag_r     <= tflag_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    diff_r      <= diff_nxt;
    rem_r       <= rem_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    sq_r        <= sq_nxt;
    root_r      <= root_nxt;
    k_r         <= k_nxt;
    base_r      <= base_nxt;
    t_r         <= t_nxt;
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    lsp_r       <= lsp_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_dv_r    <= out_dv_nxt;
    out_mov_r   <= out_mov_nxt;
    out_tmo_r   <= out_tmo_nxt;
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid       = out_valid_r;
  assign out_left_cmd    = out_left_r;
  assign out_right_speed = out_right_r;
  assign out_drive_valid = out_dv_r;
  assign out_moving      = out_mov_r;
  assign out_timeout_hit = out_tmo_r;

endmodule
